[src/lcvb_pkg.sv]
// Package for the LRU cache with victim buffer: sizes, set row layout, FSM state type.
// Used by lcvb_victim_buf and lru_cache_with_victim_buffer.
package lcvb_pkg;
  localparam int SETS           = 256;
  localparam int WAYS           = 4;
  localparam int VICTIM_ENTRIES = 8;
  localparam int TAG_BITS       = 24;
  localparam int SET_BITS       = 8;
  localparam int WAY_BITS       = 2;
  localparam int VIC_BITS       = 3;
  localparam int KEY_BITS       = SET_BITS + TAG_BITS;

  localparam logic [1:0] CFG_WRITE_MODE = 2'd0;
  localparam logic [1:0] CFG_WAYS       = 2'd1;
  localparam logic [1:0] CFG_VICTIMS    = 2'd2;

  // One set of the L1: valid bits, tags per way, recency order (position 0 most recent).
  typedef struct packed {
    logic [WAYS-1:0]                vld;
    logic [WAYS-1:0][TAG_BITS-1:0]  tag;
    logic [WAYS-1:0][WAY_BITS-1:0]  ord;
  } row_t;

  // Victim buffer request from the lookup stage.
  typedef struct packed {
    logic                update;
    logic [KEY_BITS-1:0] key;
    logic [3:0]          n;
    logic                ins_vld;
    logic [KEY_BITS-1:0] ins_line;
  } vb_req_t;

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_LOOK} st_t;
endpackage

[src/lcvb_victim_buf.sv]
// Fully associative LRU victim buffer held in flops: search, remove on hit, insert.
// Depends on lcvb_pkg.
module lcvb_victim_buf import lcvb_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  vb_req_t req,
  output logic    found,
  output logic    dropped
);
  logic [VICTIM_ENTRIES-1:0]               vld_r, vld_rm, vld_nxt;
  logic [VICTIM_ENTRIES-1:0][KEY_BITS-1:0] line_r, line_rm, line_nxt;
  logic [VIC_BITS-1:0]                     pos;

  always_comb begin
    found = 1'b0;
    pos   = '0;
    for (int i = 0; i < VICTIM_ENTRIES; i++) begin
      if (!found && 4'(i) < req.n && vld_r[i] && line_r[i] == req.key) begin
        found = 1'b1;
        pos   = VIC_BITS'(i);
      end
    end
    // drop the hit entry, close the gap
    vld_rm  = vld_r;
    line_rm = line_r;
    if (found) begin
      for (int i = 0; i < VICTIM_ENTRIES; i++) begin
        if (VIC_BITS'(i) >= pos && 4'(i + 1) < req.n) begin
          vld_rm[i]  = vld_r[i+1];
          line_rm[i] = line_r[i+1];
        end
        if (4'(i + 1) == req.n) vld_rm[i] = 1'b0;
      end
    end
    dropped  = 1'b0;
    vld_nxt  = vld_rm;
    line_nxt = line_rm;
    if (req.ins_vld) begin
      for (int i = 0; i < VICTIM_ENTRIES; i++) begin
        if (4'(i + 1) == req.n) dropped = vld_rm[i];
        if (4'(i) < req.n) begin
          if (i == 0) begin
            vld_nxt[i]  = 1'b1;
            line_nxt[i] = req.ins_line;
          end else begin
            vld_nxt[i]  = vld_rm[i-1];
            line_nxt[i] = line_rm[i-1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (req.update) begin
      vld_r <= vld_nxt;
    end
    if (req.update) line_r <= line_nxt;
  end
endmodule

[src/lru_cache_with_victim_buffer.sv]
// Top level: L1 set memory (tags, valid bits, recency order per set) plus victim buffer.
// Depends on lcvb_pkg and lcvb_victim_buf.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | func, line_tag, set_sel
//  out_    | output    | out_valid/out_stall| l1_hit, victim_hit, memory_fetch, memory_writes
//  cfg_    | input     | cfg_valid/cfg_ready| cfg_index (0..2), cfg_data
//
// For each word the set row is first read from the single-port set memory; then the row is
// updated, written back and the result register loaded.
// After reset a clearing pass writes all 256 set rows; no word is taken then.
// A waiting result does not block acceptance of the next word; the lookup holds its
// row until the result register frees up.
module lru_cache_with_victim_buffer import lcvb_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_func,
  input  logic [TAG_BITS-1:0] in_line_tag,
  input  logic [SET_BITS-1:0] in_set_sel,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_l1_hit,
  output logic                out_victim_hit,
  output logic                out_memory_fetch,
  output logic [1:0]          out_memory_writes,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [3:0]          cfg_data
);
  st_t st_r, st_nxt;
  logic [SET_BITS-1:0] clr_cnt_r;
  logic                mode_r;
  logic [2:0]          ways_r;
  logic [3:0]          vics_r;
  logic                func_r;
  logic [TAG_BITS-1:0] tag_r;
  logic [SET_BITS-1:0] set_r;

  row_t mem [SETS];
  row_t rd_q, wr_row, clr_row;
  logic                we, re;
  logic [SET_BITS-1:0] wa;

  logic                out_valid_r, l1_hit_r, vhit_r, fetch_r;
  logic [1:0]          writes_r;

  logic                accept, fire, slot_free, bypass, l1_hit;
  logic [WAY_BITS-1:0] hit_pos, lru_pos, lru_way;
  logic [2:0]          w_act;
  logic [3:0]          n_act;
  vb_req_t             vreq;
  logic                v_found, v_dropped;

  assign cfg_ready = 1'b1;
  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (st_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign fire      = (st_r == ST_LOOK) && slot_free;

  // saturate the active counts
  assign w_act = (ways_r == 3'd0) ? 3'd1 : (ways_r > 3'(WAYS)) ? 3'(WAYS) : ways_r;
  assign n_act = (vics_r == 4'd0) ? 4'd1 :
                 (vics_r > 4'(VICTIM_ENTRIES)) ? 4'(VICTIM_ENTRIES) : vics_r;

  always_comb begin
    clr_row = '0;
    for (int i = 0; i < WAYS; i++) clr_row.ord[i] = WAY_BITS'(i);
  end

  // lookup and row update
  always_comb begin
    l1_hit  = 1'b0;
    hit_pos = '0;
    for (int p = 0; p < WAYS; p++) begin
      if (!l1_hit && 3'(p) < w_act && rd_q.vld[rd_q.ord[p]] &&
          rd_q.tag[rd_q.ord[p]] == tag_r) begin
        l1_hit  = 1'b1;
        hit_pos = WAY_BITS'(p);
      end
    end
    bypass  = !l1_hit && func_r && mode_r;
    lru_pos = WAY_BITS'(w_act - 3'd1);
    lru_way = rd_q.ord[lru_pos];
    wr_row  = rd_q;
    if (l1_hit) begin
      for (int i = 0; i < WAYS; i++) begin
        if (i == 0) wr_row.ord[i] = rd_q.ord[hit_pos];
        else if (WAY_BITS'(i) <= hit_pos) wr_row.ord[i] = rd_q.ord[i-1];
      end
    end else if (!bypass) begin
      for (int i = 0; i < WAYS; i++) begin
        if (i == 0) wr_row.ord[i] = lru_way;
        else if (WAY_BITS'(i) <= lru_pos) wr_row.ord[i] = rd_q.ord[i-1];
      end
      wr_row.tag[lru_way] = tag_r;
      wr_row.vld[lru_way] = 1'b1;
    end
    vreq.update   = fire && !l1_hit && !bypass;
    vreq.key      = {set_r, tag_r};
    vreq.n        = n_act;
    vreq.ins_vld  = rd_q.vld[lru_way];
    vreq.ins_line = {set_r, rd_q.tag[lru_way]};
  end

  lcvb_victim_buf u_vb (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (vreq),
    .found   (v_found),
    .dropped (v_dropped)
  );

  // set memory port control
  always_comb begin
    re = accept;
    we = 1'b0;
    wa = set_r;
    st_nxt = st_r;
    case (st_r)
      ST_CLEAR: begin
        we = 1'b1;
        wa = clr_cnt_r;
        if (clr_cnt_r == SET_BITS'(SETS - 1)) st_nxt = ST_IDLE;
      end
      ST_IDLE: if (accept) st_nxt = ST_LOOK;
      ST_LOOK: begin
        we = fire;
        if (fire) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= (st_r == ST_CLEAR) ? clr_row : wr_row;
    if (re) rd_q <= mem[in_set_sel];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_CLEAR;
      clr_cnt_r   <= '0;
      mode_r      <= 1'b0;
      ways_r      <= 3'd4;
      vics_r      <= 4'd8;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_CLEAR) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_WRITE_MODE: mode_r <= cfg_data[0];
          CFG_WAYS:       ways_r <= cfg_data[2:0];
          CFG_VICTIMS:    vics_r <= cfg_data;
          default: ;
        endcase
      end
      if (fire) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // hold the word and the result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= in_func;
      tag_r  <= in_line_tag;
      set_r  <= in_set_sel;
    end
    if (fire) begin
      l1_hit_r <= l1_hit;
      vhit_r   <= !l1_hit && !bypass && v_found;
      fetch_r  <= !l1_hit && !bypass && !v_found && !func_r;
      writes_r <= 2'(bypass || (!l1_hit && !v_found && func_r))
                + 2'(vreq.update && vreq.ins_vld && v_dropped);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_l1_hit        = l1_hit_r;
  assign out_victim_hit    = vhit_r;
  assign out_memory_fetch  = fetch_r;
  assign out_memory_writes = writes_r;
endmodule
